// ----- hw/rtl/wdr_pkg.sv -----
// Shared types, constants and helpers for the wheel drive ramp block.
// Used by the top level and its port checker; no dependencies.
`default_nettype none

package wdr_pkg;

  // Trim history ring.
  localparam int HistDepth = 150;
  localparam int Lookback  = 120;
  localparam int HistAw    = $clog2(HistDepth);
  localparam int LbDist    = (Lookback > HistDepth - 1) ? HistDepth - 1 : Lookback;
  localparam int LbWrap    = HistDepth - LbDist;

  // Field widths.
  localparam int PulseW  = 11;
  localparam int SpeedW  = 5;
  localparam int CodeW   = 8;
  localparam int MeasW   = 10;
  localparam int TrimW   = 7;
  localparam int LimitW  = 6;
  localparam int CfgIdxW = 2;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgIdlePulse  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBasePulse  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOffsetLim  = 2'd2;

  // Item kinds.
  localparam logic KindTick     = 1'b0;
  localparam logic KindFeedback = 1'b1;

  // Reset values.
  localparam logic [PulseW-1:0] IdlePulseRst = 11'd1000;
  localparam logic [PulseW-1:0] BasePulseRst = 11'd1115;
  localparam logic [LimitW-1:0] OffsetLimRst = 6'd20;
  localparam logic [PulseW-1:0] RampRst      = 11'd1000;

  // Supported speed codes.
  localparam logic [SpeedW-1:0] Speed16 = 5'd16;
  localparam logic [SpeedW-1:0] Speed18 = 5'd18;
  localparam logic [SpeedW-1:0] Speed21 = 5'd21;
  localparam logic [SpeedW-1:0] Speed25 = 5'd25;
  localparam logic [SpeedW-1:0] Speed28 = 5'd28;
  localparam logic [SpeedW-1:0] SpeedIdleBelow = 5'd12;
  localparam logic [SpeedW-1:0] SpeedBase      = 5'd10;

  typedef struct packed {
    logic [PulseW-1:0]       drive_value;
    logic [SpeedW-1:0]       target_speed;
    logic signed [TrimW-1:0] speed_offset;
  } result_t;

  function automatic logic [SpeedW-1:0] accept_speed(input logic [CodeW-1:0] code);
    logic [SpeedW-1:0] res;
    res = '0;
    if (code[CodeW-1:SpeedW] == '0) begin
      if (code[SpeedW-1:0] == Speed16 || code[SpeedW-1:0] == Speed18 ||
          code[SpeedW-1:0] == Speed21 || code[SpeedW-1:0] == Speed25 ||
          code[SpeedW-1:0] == Speed28) begin
        res = code[SpeedW-1:0];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wheel_drive_ramp_with_speed_trim.sv -----
// Wheel drive ramp with adaptive speed trim: top level.
// Depends on wdr_pkg and wdr_hist_ram.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one word per item.
// A tick word (kind 0) sets the target speed, moves the drive value one step
// toward the target pulse and records the current trim in the history ring.
// A feedback word (kind 1) recomputes the trim from the history entry a fixed
// number of ticks back plus the measured speed error.
// Every accepted word yields one result word on the output channel
// (out_valid_o / out_stall_i), in order.
// A tick result is written into the output queue when the tick is accepted, a
// feedback result once fb_busy_q is set, since it waits on the history RAM read port.
// Throughput: ticks are taken every cycle while in_stall_o is low; a feedback word
// stalls the input through fb_busy_q while its RAM read completes.
// Results sit in a two-word output queue, so input is taken while a result
// waits; whenever the queue is full, in_stall_o rises.
// Reset clears the ring valid flags (all entries read as zero), the drive value
// to 1000, target and trim to zero, and the registers to their defaults.
// Configuration writes via cfg_valid_i / cfg_ready_o are always taken; an
// index past the last register is ignored.
`default_nettype none

module wheel_drive_ramp_with_speed_trim (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wdr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [wdr_pkg::PulseW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           in_kind_i,
  input  logic [wdr_pkg::CodeW-1:0]      in_bullet_speed_i,
  input  logic [wdr_pkg::MeasW-1:0]      in_measured_speed_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [wdr_pkg::PulseW-1:0]     out_drive_value_o,
  output logic [wdr_pkg::SpeedW-1:0]     out_target_speed_o,
  output logic signed [wdr_pkg::TrimW-1:0] out_speed_offset_o
);

  import wdr_pkg::*;

  // Configuration registers.
  logic [PulseW-1:0] idle_pulse_q, base_pulse_q;
  logic [LimitW-1:0] offset_lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_pulse_q <= IdlePulseRst;
      base_pulse_q <= BasePulseRst;
      offset_lim_q <= OffsetLimRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgIdlePulse: idle_pulse_q <= cfg_data_i;
        CfgBasePulse: base_pulse_q <= cfg_data_i;
        CfgOffsetLim: offset_lim_q <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // State.
  logic [PulseW-1:0]       ramp_q, ramp_d;
  logic [SpeedW-1:0]       target_q, target_d;
  logic signed [TrimW-1:0] trim_q, trim_d;
  logic [HistAw-1:0]       ptr_q, ptr_d;
  logic [HistDepth-1:0]    hist_vld_q;
  logic                    rd_vld_q;
  logic                    fb_busy_q;
  logic [MeasW-1:0]        meas_q;

  // Output queue.
  result_t    oq_q [2];
  logic       oq_rd_q, oq_wr_q;
  logic [1:0] oq_cnt_q;
  logic       push, pop;
  result_t    push_data;

  logic in_acc, tick_acc, fb_acc;

  assign in_stall_o = fb_busy_q || (oq_cnt_q == 2'd2);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (in_kind_i == KindTick);
  assign fb_acc     = in_acc && (in_kind_i == KindFeedback);

  // History ring: written on ticks, read at the lookback slot every cycle.
  logic [HistAw-1:0]       raddr;
  logic [TrimW-1:0]        rdata;
  logic signed [TrimW-1:0] entry;

  assign raddr = (ptr_q >= HistAw'(LbDist)) ? ptr_q - HistAw'(LbDist)
                                            : ptr_q + HistAw'(LbWrap);

  wdr_hist_ram #(
    .Depth (HistDepth),
    .Width (TrimW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (tick_acc),
    .waddr_i (ptr_q),
    .wdata_i (trim_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // An entry never written since reset reads as zero.
  assign entry = rd_vld_q ? $signed(rdata) : '0;

  // Tick path: target pulse and one ramp step.
  logic [SpeedW-1:0]  tick_target;
  logic signed [12:0] pulse_sum;
  logic [PulseW-1:0]  pulse;

  always_comb begin
    tick_target = accept_speed(in_bullet_speed_i);
    pulse_sum = $signed({2'b00, base_pulse_q}) + 13'(trim_q)
              + 13'($signed({1'b0, tick_target}) - $signed({1'b0, SpeedBase})) * 13'sd5;
    if (tick_target < SpeedIdleBelow) begin
      pulse = idle_pulse_q;
    end else if (pulse_sum < 0) begin
      pulse = '0;
    end else if (pulse_sum > 13'sd2047) begin
      pulse = '1;
    end else begin
      pulse = pulse_sum[PulseW-1:0];
    end
  end

  // Feedback path: trim from the lookback entry plus twice the speed error.
  logic signed [11:0] err16, sum8;
  logic signed [8:0]  quot, lim, fb_trim;
  logic               fb_update;

  always_comb begin
    err16 = $signed({3'b000, target_q, 4'b0000}) - $signed({2'b00, meas_q});
    sum8  = 12'($signed({entry, 3'b000})) + err16;
    // Arithmetic shift floors; bump negative values with a remainder toward zero.
    quot  = 9'(sum8 >>> 3);
    if (sum8 < 0 && sum8[2:0] != 3'b000) begin
      quot = quot + 9'sd1;
    end
    lim = $signed({3'b000, offset_lim_q});
    if (quot > lim) begin
      fb_trim = lim;
    end else if (quot < -lim) begin
      fb_trim = -lim;
    end else begin
      fb_trim = quot;
    end
    fb_update = (target_q != '0) && (err16 > 12'sd16 || err16 < -12'sd16);
  end

  always_comb begin
    ramp_d   = ramp_q;
    target_d = target_q;
    trim_d   = trim_q;
    ptr_d    = ptr_q;
    if (tick_acc) begin
      target_d = tick_target;
      if (ramp_q > pulse) begin
        ramp_d = ramp_q - 1'b1;
      end else if (ramp_q < pulse) begin
        ramp_d = ramp_q + 1'b1;
      end
      ptr_d = (ptr_q == HistAw'(HistDepth - 1)) ? '0 : ptr_q + 1'b1;
    end
    if (fb_busy_q && fb_update) begin
      trim_d = fb_trim[TrimW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q     <= RampRst;
      target_q   <= '0;
      trim_q     <= '0;
      ptr_q      <= '0;
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      fb_busy_q  <= 1'b0;
    end else begin
      ramp_q    <= ramp_d;
      target_q  <= target_d;
      trim_q    <= trim_d;
      ptr_q     <= ptr_d;
      rd_vld_q  <= hist_vld_q[raddr];
      fb_busy_q <= fb_acc;
      if (tick_acc) begin
        hist_vld_q[ptr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fb_acc) begin
      meas_q <= in_measured_speed_i;
    end
  end

  // Result words: ticks push at acceptance, feedback once fb_busy_q is set.
  assign push = tick_acc || fb_busy_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    push_data.drive_value  = ramp_d;
    push_data.target_speed = target_d;
    push_data.speed_offset = trim_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_rd_q  <= 1'b0;
      oq_wr_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      if (push) begin
        oq_wr_q <= ~oq_wr_q;
      end
      if (pop) begin
        oq_rd_q <= ~oq_rd_q;
      end
      case ({push, pop})
        2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
        2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
        default: oq_cnt_q <= oq_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_q[oq_wr_q] <= push_data;
    end
  end

  assign out_valid_o        = (oq_cnt_q != 2'd0);
  assign out_drive_value_o  = oq_q[oq_rd_q].drive_value;
  assign out_target_speed_o = oq_q[oq_rd_q].target_speed;
  assign out_speed_offset_o = oq_q[oq_rd_q].speed_offset;

endmodule

`default_nettype wire

// ----- hw/rtl/wdr_hist_ram.sv -----
// Generic single-write, single-read synchronous RAM for the trim history.
// Read data is registered; no dependencies.
`default_nettype none

module wdr_hist_ram #(
  parameter int Depth = 150,
  parameter int Width = 7
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/wdr_checker.sv -----
// Port-level checker for the wheel drive ramp block, bound to its top level.
// Depends on wdr_pkg and wheel_drive_ramp_with_speed_trim.
`default_nettype none

module wdr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             in_kind_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [wdr_pkg::PulseW-1:0]       out_drive_value_o,
  input logic [wdr_pkg::SpeedW-1:0]       out_target_speed_o,
  input logic signed [wdr_pkg::TrimW-1:0] out_speed_offset_o
);

  import wdr_pkg::*;

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_drive_value_o) &&
      $stable(out_target_speed_o) && $stable(out_speed_offset_o))
    else $error("result payload changed while stalled");

  // Only supported speeds, or zero, are ever reported as target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_target_speed_o == '0 || out_target_speed_o == Speed16 ||
      out_target_speed_o == Speed18 || out_target_speed_o == Speed21 ||
      out_target_speed_o == Speed25 || out_target_speed_o == Speed28))
    else $error("unsupported target speed reported");

  // A feedback word holds the input for its RAM read cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_kind_i == KindFeedback) |=> in_stall_o)
    else $error("input taken during feedback read");

  // After an accepted word the output queue does not stay empty: a word
  // taken with an empty queue later shows up as out_valid_o.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |-> ##2 out_valid_o || $past(out_valid_o))
    else $error("result word missing after accepted input");

endmodule

bind wheel_drive_ramp_with_speed_trim wdr_checker u_wdr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .in_kind_i          (in_kind_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .out_drive_value_o  (out_drive_value_o),
  .out_target_speed_o (out_target_speed_o),
  .out_speed_offset_o (out_speed_offset_o)
);

`default_nettype wire
